### rtl/core/battery_level_display_smoother_top_macros.svh
// assertion macros for the battery level display smoother
// used by the rtl modules that carry concurrent checks; no other dependencies
`ifndef BATTERY_LEVEL_DISPLAY_SMOOTHER_TOP_MACROS_SVH
`define BATTERY_LEVEL_DISPLAY_SMOOTHER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BLDS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blds check failed");

// next-cycle implication, disabled during reset
`define BLDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blds check failed");

`endif

### rtl/core/blds_pkg.sv
// shared types, constants and register indexes for the display smoother
// no dependencies
package blds_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int LEVEL_BITS        = 7;
   localparam int RAW_BITS          = 8;
   localparam int STATUS_BITS       = 2;
   localparam int NOW_BITS          = 32;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'd100;

   localparam logic [CSR_DATA_BITS-1:0] STABLE_WINDOW_RESET = 32'd15000;
   localparam logic [CSR_DATA_BITS-1:0] STEP_INTERVAL_RESET = 32'd60000;
   localparam logic [CSR_DATA_BITS-1:0] RESYNC_GAP_RESET    = 32'd60000;
   localparam logic [LEVEL_BITS-1:0]    JUMP_RESET          = 7'd5;
   localparam logic [LEVEL_BITS-1:0]    CRITICAL_RESET      = 7'd5;
   localparam logic [LEVEL_BITS-1:0]    FULL_RESET          = 7'd99;

   localparam logic [STATUS_BITS-1:0] CHG_DISCHARGING = 2'd0;
   localparam logic [STATUS_BITS-1:0] CHG_CHARGING    = 2'd1;
   localparam logic [STATUS_BITS-1:0] CHG_FULL        = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STABLE_WINDOW = 3'd0,
      CSR_STEP_INTERVAL = 3'd1,
      CSR_RESYNC_GAP    = 3'd2,
      CSR_JUMP          = 3'd3,
      CSR_CRITICAL      = 3'd4,
      CSR_FULL          = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] stable_window_ms;
      logic [CSR_DATA_BITS-1:0] step_interval_ms;
      logic [CSR_DATA_BITS-1:0] resync_gap_ms;
      logic [LEVEL_BITS-1:0]    jump_threshold;
      logic [LEVEL_BITS-1:0]    critical_level;
      logic [LEVEL_BITS-1:0]    full_level;
   } cfg_type;

   typedef struct packed {
      logic                  result_valid;
      logic [LEVEL_BITS-1:0] display_level;
   } rsp_word_type;

   function automatic logic [LEVEL_BITS-1:0] saturate_level(input logic [RAW_BITS-1:0] raw);
      logic [LEVEL_BITS-1:0] res;
      res = (raw > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : raw[LEVEL_BITS-1:0];
      return res;
   endfunction

endpackage

### rtl/core/battery_level_display_smoother_top.sv
// top level of the battery level display smoother
// depends on blds_pkg, blds_csr, blds_core, blds_rsp_buf
//
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  reading_valid, raw_level, charge_status, now_ms
// rsp       out        rsp_valid/rsp_stall  result_valid, display_level
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// one word a cycle while req_stall is low; results are registered before rsp
// the whole update is one pass of compare logic on the state registers
// synchronous active-high reset clears the smoothing state and loads csr defaults
// rsp has an output register and a skid entry; req stalls only with both full
// configuration is to be changed only while idle; the block itself does not enforce it
module battery_level_display_smoother_top #(
   parameter int TIME_BITS = blds_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_reading_valid,
   input  logic [blds_pkg::RAW_BITS-1:0]       req_raw_level,
   input  logic [blds_pkg::STATUS_BITS-1:0]    req_charge_status,
   input  logic [blds_pkg::NOW_BITS-1:0]       req_now_ms,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_valid,
   output logic [blds_pkg::LEVEL_BITS-1:0]     rsp_display_level,
   // configuration port
   input  logic                                csr_write_enable,
   input  logic [blds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [blds_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import blds_pkg::*;

   cfg_type      cfg;
   rsp_word_type word;
   rsp_word_type out_word;
   logic         buf_full;
   logic         accept;

   // a word is taken whenever the skid entry is free
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // register bank, written directly from the csr port
   blds_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // smoothing state; updates on every accepted good reading
   blds_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .reading_valid (req_reading_valid),
      .raw_level     (req_raw_level),
      .charge_status (req_charge_status),
      .now_ms        (req_now_ms),
      .word          (word)
   );

   // result register with skid entry, parts req from rsp stalls
   blds_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (word),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (out_word)
   );

   assign rsp_result_valid  = out_word.result_valid;
   assign rsp_display_level = out_word.display_level;

endmodule

### rtl/core/blds_csr.sv
// configuration register bank of the display smoother
// depends on blds_pkg
module blds_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [blds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [blds_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output blds_pkg::cfg_type                    cfg
);
   import blds_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STABLE_WINDOW: cfg_in.stable_window_ms = csr_write_data;
            CSR_STEP_INTERVAL: cfg_in.step_interval_ms = csr_write_data;
            CSR_RESYNC_GAP:    cfg_in.resync_gap_ms    = csr_write_data;
            CSR_JUMP:          cfg_in.jump_threshold   = csr_write_data[LEVEL_BITS-1:0];
            CSR_CRITICAL:      cfg_in.critical_level   = csr_write_data[LEVEL_BITS-1:0];
            CSR_FULL:          cfg_in.full_level       = csr_write_data[LEVEL_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_window_ms <= STABLE_WINDOW_RESET;
         cfg_ff.step_interval_ms <= STEP_INTERVAL_RESET;
         cfg_ff.resync_gap_ms    <= RESYNC_GAP_RESET;
         cfg_ff.jump_threshold   <= JUMP_RESET;
         cfg_ff.critical_level   <= CRITICAL_RESET;
         cfg_ff.full_level       <= FULL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/blds_core.sv
// smoothing state and single-pass update logic of the display smoother
// depends on blds_pkg
module blds_core #(
   parameter int TIME_BITS = blds_pkg::TIME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  blds_pkg::cfg_type                  cfg,
   input  logic                               accept,
   input  logic                               reading_valid,
   input  logic [blds_pkg::RAW_BITS-1:0]      raw_level,
   input  logic [blds_pkg::STATUS_BITS-1:0]   charge_status,
   input  logic [blds_pkg::NOW_BITS-1:0]      now_ms,
   output blds_pkg::rsp_word_type             word
);
   import blds_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > CSR_DATA_BITS) ? TIME_BITS : CSR_DATA_BITS;

   logic [LEVEL_BITS-1:0] shown_ff, shown_in;
   logic                  shown_valid_ff, shown_valid_in;
   logic [LEVEL_BITS-1:0] cand_ff, cand_in;
   logic                  powered_ff, powered_in;
   logic [TIME_BITS-1:0]  since_ff, since_in;
   logic [TIME_BITS-1:0]  step_ff, step_in;
   logic [TIME_BITS-1:0]  poll_ff;
   logic                  poll_valid_ff;

   logic [TIME_BITS-1:0]  now_t;
   logic [LEVEL_BITS-1:0] raw_sat;
   logic                  powered;
   logic                  stale_poll;
   logic                  resync;
   logic                  power_change;
   logic [LEVEL_BITS-1:0] cand_mid;
   logic [TIME_BITS-1:0]  since_mid;
   logic [TIME_BITS-1:0]  step_mid;
   logic [TIME_BITS-1:0]  poll_age;
   logic [TIME_BITS-1:0]  since_age;
   logic [TIME_BITS-1:0]  step_age;
   logic                  stable_ok;
   logic                  step_ok;
   logic                  up;
   logic                  down;
   logic [LEVEL_BITS-1:0] gap;
   logic                  update;

   assign now_t      = TIME_BITS'(now_ms);
   assign raw_sat    = saturate_level(raw_level);
   assign powered    = (charge_status == CHG_CHARGING) || (charge_status == CHG_FULL);
   assign poll_age   = now_t - poll_ff;
   assign stale_poll = poll_valid_ff &&
                       (CMP_BITS'(poll_age) >= CMP_BITS'(cfg.resync_gap_ms));
   assign resync     = !shown_valid_ff || stale_poll;
   assign update     = accept && reading_valid;

   // candidate tracking ahead of the display decision
   assign power_change = (powered != powered_ff);
   assign cand_mid     = (power_change || (raw_sat != cand_ff)) ? raw_sat : cand_ff;
   assign since_mid    = (power_change || (raw_sat != cand_ff)) ? now_t : since_ff;
   assign step_mid     = power_change ? now_t : step_ff;

   // time differences wrap at the timestamp width
   assign since_age = now_t - since_mid;
   assign step_age  = now_t - step_mid;

   assign stable_ok = CMP_BITS'(since_age) >= CMP_BITS'(cfg.stable_window_ms);
   assign step_ok   = CMP_BITS'(step_age) >= CMP_BITS'(cfg.step_interval_ms);
   assign up        = powered && (cand_mid > shown_ff);
   assign down      = !powered && (cand_mid < shown_ff);
   assign gap       = up ? (cand_mid - shown_ff) : (shown_ff - cand_mid);

   always_comb begin
      shown_in       = shown_ff;
      shown_valid_in = shown_valid_ff;
      cand_in        = cand_ff;
      powered_in     = powered_ff;
      since_in       = since_ff;
      step_in        = step_ff;
      if (resync) begin
         shown_in       = raw_sat;
         shown_valid_in = 1'b1;
         cand_in        = raw_sat;
         powered_in     = powered;
         since_in       = now_t;
         step_in        = now_t;
      end else begin
         cand_in    = cand_mid;
         powered_in = powered;
         since_in   = since_mid;
         step_in    = step_mid;
         priority if (!powered && (raw_sat <= cfg.critical_level)) begin
            shown_in = raw_sat;
            step_in  = now_t;
         end else if ((charge_status == CHG_FULL) && (raw_sat >= cfg.full_level)) begin
            shown_in = LEVEL_MAX;
            step_in  = now_t;
         end else if (stable_ok && (up || down)) begin
            if (gap >= cfg.jump_threshold) begin
               shown_in = raw_sat;
               step_in  = now_t;
            end else if (step_ok) begin
               shown_in = up ? (shown_ff + 7'd1) : (shown_ff - 7'd1);
               step_in  = now_t;
            end
         end else begin
            // display holds
            shown_in = shown_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff       <= '0;
         shown_valid_ff <= 1'b0;
         cand_ff        <= '0;
         powered_ff     <= 1'b0;
         since_ff       <= '0;
         step_ff        <= '0;
         poll_ff        <= '0;
         poll_valid_ff  <= 1'b0;
      end else if (update) begin
         shown_ff       <= shown_in;
         shown_valid_ff <= shown_valid_in;
         cand_ff        <= cand_in;
         powered_ff     <= powered_in;
         since_ff       <= since_in;
         step_ff        <= step_in;
         poll_ff        <= now_t;
         poll_valid_ff  <= 1'b1;
      end
   end

   // failed readings give an invalid zero word
   assign word.result_valid  = reading_valid;
   assign word.display_level = reading_valid ? shown_in : '0;

endmodule

### rtl/core/blds_rsp_buf.sv
// two-entry result buffer (output register plus skid) of the display smoother
// depends on blds_pkg and the assertion macro header
`include "battery_level_display_smoother_top_macros.svh"
module blds_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  blds_pkg::rsp_word_type  push_word,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output blds_pkg::rsp_word_type  rsp_word
);
   import blds_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_word_in  = push_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = push_word;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `BLDS_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `BLDS_ASSERT_IMPL(a_no_push_when_full, clock, reset, skid_valid_ff, !push)
   `BLDS_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, out_valid_ff && !skid_valid_ff && (out_word_ff == $past(skid_word_ff)))

endmodule

### tb/tb_battery_level_display_smoother_top.sv
// self-checking testbench for battery_level_display_smoother_top
// depends on blds_pkg and the rtl of the smoother; a scoreboard class predicts each display word
`timescale 1ns / 1ps

module tb_battery_level_display_smoother_top;
   import blds_pkg::*;

   // scoreboard: own copy of the smoothing state and registers, plus the expected words
   class display_scoreboard;
      cfg_type                cfg;
      bit [LEVEL_BITS-1:0]    disp_level;
      bit                     disp_valid;
      bit [LEVEL_BITS-1:0]    cand_level;
      bit                     cand_powered;
      bit [NOW_BITS-1:0]      cand_start;
      bit [NOW_BITS-1:0]      step_stamp;
      bit [NOW_BITS-1:0]      poll_stamp;
      bit                     poll_seen;
      rsp_word_type           expected_displays[$];
      int unsigned            mismatches;

      function new();
         cfg.stable_window_ms = STABLE_WINDOW_RESET;
         cfg.step_interval_ms = STEP_INTERVAL_RESET;
         cfg.resync_gap_ms    = RESYNC_GAP_RESET;
         cfg.jump_threshold   = JUMP_RESET;
         cfg.critical_level   = CRITICAL_RESET;
         cfg.full_level       = FULL_RESET;
         disp_level   = '0;
         disp_valid   = 1'b0;
         cand_level   = '0;
         cand_powered = 1'b0;
         cand_start   = '0;
         step_stamp   = '0;
         poll_stamp   = '0;
         poll_seen    = 1'b0;
         mismatches   = 0;
      endfunction

      function void write_register(csr_index_type idx, bit [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_STABLE_WINDOW: cfg.stable_window_ms = data;
            CSR_STEP_INTERVAL: cfg.step_interval_ms = data;
            CSR_RESYNC_GAP:    cfg.resync_gap_ms    = data;
            CSR_JUMP:          cfg.jump_threshold   = data[LEVEL_BITS-1:0];
            CSR_CRITICAL:      cfg.critical_level   = data[LEVEL_BITS-1:0];
            CSR_FULL:          cfg.full_level       = data[LEVEL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function bit [NOW_BITS-1:0] elapsed(bit [NOW_BITS-1:0] now, bit [NOW_BITS-1:0] then_ms);
         bit [NOW_BITS-1:0] d;
         d = now - then_ms;
         return d;
      endfunction

      function int unsigned pending();
         return expected_displays.size();
      endfunction

      function void note_reading(bit ok, bit [RAW_BITS-1:0] raw_in,
                                 bit [STATUS_BITS-1:0] status, bit [NOW_BITS-1:0] now);
         rsp_word_type        exp_word;
         bit [LEVEL_BITS-1:0] raw;
         bit [LEVEL_BITS-1:0] gap;
         bit                  powered;
         bit                  stale_poll;
         bit                  up;
         bit                  down;
         exp_word = '0;
         if (!ok) begin
            expected_displays.push_back(exp_word);
            return;
         end
         raw        = (raw_in > 8'd100) ? LEVEL_MAX : raw_in[LEVEL_BITS-1:0];
         powered    = (status == CHG_CHARGING) || (status == CHG_FULL);
         stale_poll = poll_seen && (elapsed(now, poll_stamp) >= cfg.resync_gap_ms);
         poll_stamp = now;
         poll_seen  = 1'b1;
         if (!disp_valid || stale_poll) begin
            disp_level   = raw;
            disp_valid   = 1'b1;
            cand_level   = raw;
            cand_powered = powered;
            cand_start   = now;
            step_stamp   = now;
         end else begin
            if (powered != cand_powered) begin
               cand_powered = powered;
               cand_level   = raw;
               cand_start   = now;
               step_stamp   = now;
            end else if (raw != cand_level) begin
               cand_level = raw;
               cand_start = now;
            end
            if (!powered && raw <= cfg.critical_level) begin
               disp_level = raw;
               step_stamp = now;
            end else if (status == CHG_FULL && raw >= cfg.full_level) begin
               disp_level = LEVEL_MAX;
               step_stamp = now;
            end else if (elapsed(now, cand_start) >= cfg.stable_window_ms) begin
               up   = powered && (cand_level > disp_level);
               down = !powered && (cand_level < disp_level);
               if (up || down) begin
                  gap = up ? cand_level - disp_level : disp_level - cand_level;
                  if (gap >= cfg.jump_threshold) begin
                     disp_level = raw;
                     step_stamp = now;
                  end else if (elapsed(now, step_stamp) >= cfg.step_interval_ms) begin
                     disp_level = up ? disp_level + 7'd1 : disp_level - 7'd1;
                     step_stamp = now;
                  end
               end
            end
         end
         exp_word.result_valid  = 1'b1;
         exp_word.display_level = disp_level;
         expected_displays.push_back(exp_word);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_display(bit rv, bit [LEVEL_BITS-1:0] level);
         rsp_word_type exp_word;
         if (expected_displays.size() == 0) begin
            report_mismatch($sformatf("display word %0d/%0d with nothing expected", rv, level));
            return;
         end
         exp_word = expected_displays.pop_front();
         if (rv !== exp_word.result_valid)
            report_mismatch($sformatf("result_valid %0d, expected %0d",
                                      rv, exp_word.result_valid));
         if (level !== exp_word.display_level)
            report_mismatch($sformatf("display_level %0d, expected %0d",
                                      level, exp_word.display_level));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_reading_valid;
   logic [RAW_BITS-1:0]       req_raw_level;
   logic [STATUS_BITS-1:0]    req_charge_status;
   logic [NOW_BITS-1:0]       req_now_ms;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_result_valid;
   logic [LEVEL_BITS-1:0]     rsp_display_level;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   display_scoreboard sb = new();

   // sender pacing and the running poll clock
   int unsigned       burst_left = 0;
   bit [NOW_BITS-1:0] poll_clock = '0;

   // receiver stall pattern
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   battery_level_display_smoother_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_reading_valid (req_reading_valid),
      .req_raw_level     (req_raw_level),
      .req_charge_status (req_charge_status),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_display_level (rsp_display_level),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: stall mode is picked at random, from never stalling to mostly stalling
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 64);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // monitor: sample both channels at the rising edge; results first, as they can only
   // belong to words accepted at earlier edges
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_display(rsp_result_valid, rsp_display_level);
         if (req_valid && !req_stall)
            sb.note_reading(req_reading_valid, req_raw_level, req_charge_status, req_now_ms);
      end
   end

   // present one request word and hold it until the block takes it
   task automatic send_reading(bit ok, bit [RAW_BITS-1:0] raw,
                               bit [STATUS_BITS-1:0] status, bit [NOW_BITS-1:0] now);
      @(negedge clock);
      req_valid         = 1'b1;
      req_reading_valid = ok;
      req_raw_level     = raw;
      req_charge_status = status;
      req_now_ms        = now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid for a gap whose length is given by n
   task automatic hold_sender(int unsigned n);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // bursts of random length, random gaps between them
   task automatic pace_sender();
      if (burst_left == 0) begin
         hold_sender($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   // stop sending and wait for every outstanding display word
   task automatic drain_displays();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, bit [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      sb.write_register(idx, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic load_settings(cfg_type c);
      write_register(CSR_STABLE_WINDOW, c.stable_window_ms);
      write_register(CSR_STEP_INTERVAL, c.step_interval_ms);
      write_register(CSR_RESYNC_GAP, c.resync_gap_ms);
      write_register(CSR_JUMP, {25'd0, c.jump_threshold});
      write_register(CSR_CRITICAL, {25'd0, c.critical_level});
      write_register(CSR_FULL, {25'd0, c.full_level});
   endtask

   // next poll stamp: mostly small steps, some right at the window, step and resync edges,
   // some going backwards (reads as a huge gap) and a few anywhere at all
   function automatic bit [NOW_BITS-1:0] next_stamp(int unsigned scale);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         poll_clock = poll_clock + $urandom_range(0, scale);
      else if (sel < 80)
         poll_clock = poll_clock + sb.cfg.stable_window_ms + $urandom_range(0, 2) - 1;
      else if (sel < 88)
         poll_clock = poll_clock + sb.cfg.step_interval_ms + $urandom_range(0, 2) - 1;
      else if (sel < 94)
         poll_clock = poll_clock + sb.cfg.resync_gap_ms + $urandom_range(0, 1) - 1;
      else if (sel < 97)
         poll_clock = poll_clock - $urandom_range(1, 1000);
      else
         poll_clock = $urandom();
      return poll_clock;
   endfunction

   // one phase of random polls: episodes of a steady level and status with some noise
   task automatic run_phase(cfg_type c, int unsigned scale, int unsigned count, bit with_pause);
      int unsigned         sent;
      int unsigned         ep_len;
      int                  ep_level;
      bit [STATUS_BITS-1:0] ep_status;
      bit [RAW_BITS-1:0]   raw;
      bit [STATUS_BITS-1:0] status;
      int unsigned         sel;
      sent     = 0;
      ep_level = $urandom_range(0, 100);
      drain_displays();
      load_settings(c);
      while (sent < count) begin
         // new episode: usually close to the previous level
         if ($urandom_range(0, 9) < 6)
            ep_level = ep_level + $urandom_range(0, 16) - 8;
         else
            ep_level = $urandom_range(0, 100);
         if (ep_level < 0) ep_level = 0;
         if (ep_level > 100) ep_level = 100;
         ep_status = STATUS_BITS'($urandom_range(0, 2));
         ep_len    = $urandom_range(3, 15);
         repeat (ep_len) begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
               raw = RAW_BITS'(ep_level);
            else if (sel < 90)
               raw = RAW_BITS'((ep_level >= 2) ? ep_level + $urandom_range(0, 4) - 2
                                               : ep_level);
            else
               raw = RAW_BITS'($urandom_range(0, 255));
            status = ($urandom_range(0, 19) == 0) ? STATUS_BITS'($urandom_range(0, 3))
                                                  : ep_status;
            send_reading($urandom_range(0, 9) != 0, raw, status, next_stamp(scale));
            sent++;
            // hold off once until the block has answered everything
            if (with_pause && sent == count / 2)
               drain_displays();
            pace_sender();
         end
      end
   endtask

   // stimulus
   initial begin
      cfg_type c;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_reading_valid = 1'b0;
      req_raw_level     = '0;
      req_charge_status = CHG_DISCHARGING;
      req_now_ms        = '0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_STABLE_WINDOW;
      csr_write_data    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on the reset settings
      send_reading(1'b0, 8'd255, 2'd3, 32'hFFFF_FFFF); // failed word before anything shown
      send_reading(1'b1, 8'd200, CHG_DISCHARGING, 32'd1000); // first reading, saturated
      send_reading(1'b1, 8'd60, CHG_DISCHARGING, 32'd2000);
      send_reading(1'b1, 8'd60, CHG_DISCHARGING, 32'd17000); // stable, big drop snaps
      send_reading(1'b1, 8'd58, CHG_DISCHARGING, 32'd20000);
      send_reading(1'b1, 8'd58, CHG_DISCHARGING, 32'd35000); // stable but step timer not due
      send_reading(1'b1, 8'd58, CHG_DISCHARGING, 32'd80000); // one step down
      send_reading(1'b1, 8'd58, CHG_DISCHARGING, 32'd125000);
      send_reading(1'b1, 8'd58, CHG_CHARGING, 32'd126000); // no rise while charging yet
      send_reading(1'b1, 8'd4, CHG_DISCHARGING, 32'd127000); // critical passes through
      send_reading(1'b1, 8'd4, CHG_CHARGING, 32'd128000); // power change restarts window
      send_reading(1'b1, 8'd99, CHG_FULL, 32'd129000); // full shows 100
      send_reading(1'b1, 8'd50, 2'd3, 32'd130000); // status three counts as discharging
      send_reading(1'b1, 8'd0, CHG_DISCHARGING, 32'd131000);
      send_reading(1'b1, 8'd100, CHG_FULL, 32'd132000);
      send_reading(1'b1, 8'd101, CHG_CHARGING, 32'd133000);
      send_reading(1'b1, 8'd70, CHG_CHARGING, 32'd140000);
      send_reading(1'b1, 8'd70, CHG_CHARGING, 32'd155000); // stable, but no drop while charging: display holds
      send_reading(1'b0, 8'd10, CHG_DISCHARGING, 32'd156000); // failed word leaves state alone
      send_reading(1'b1, 8'd71, CHG_CHARGING, 32'hFFFF_FFFF);
      send_reading(1'b1, 8'd72, CHG_CHARGING, 32'd16); // wraps forward: short gap
      send_reading(1'b1, 8'd30, CHG_DISCHARGING, 32'd5); // backwards: long gap, resync
      send_reading(1'b1, 8'd255, CHG_FULL, 32'd6);
      send_reading(1'b1, 8'd128, CHG_DISCHARGING, 32'd7);
      poll_clock = 32'd10;

      // reset settings, large time steps
      c.stable_window_ms = STABLE_WINDOW_RESET;
      c.step_interval_ms = STEP_INTERVAL_RESET;
      c.resync_gap_ms    = RESYNC_GAP_RESET;
      c.jump_threshold   = JUMP_RESET;
      c.critical_level   = CRITICAL_RESET;
      c.full_level       = FULL_RESET;
      run_phase(c, 20000, 125, 1'b0);

      // short windows so that steps and snaps come often
      c.stable_window_ms = 32'd100;
      c.step_interval_ms = 32'd200;
      c.resync_gap_ms    = 32'd2000;
      c.jump_threshold   = 7'd10;
      c.critical_level   = 7'd5;
      c.full_level       = 7'd95;
      run_phase(c, 150, 125, 1'b1);

      // lower extremes: no waiting anywhere, resync only on a gap of all ones
      c.stable_window_ms = '0;
      c.step_interval_ms = '0;
      c.resync_gap_ms    = 32'hFFFF_FFFF;
      c.jump_threshold   = 7'd0;
      c.critical_level   = 7'd0;
      c.full_level       = 7'd0;
      run_phase(c, 100, 125, 1'b0);

      // upper extremes: every poll resyncs
      c.stable_window_ms = 32'hFFFF_FFFF;
      c.step_interval_ms = 32'hFFFF_FFFF;
      c.resync_gap_ms    = '0;
      c.jump_threshold   = LEVEL_MAX;
      c.critical_level   = LEVEL_MAX;
      c.full_level       = LEVEL_MAX;
      run_phase(c, 100, 125, 1'b0);

      // stepping, with snaps only on a gap of the full range
      c.stable_window_ms = 32'd50;
      c.step_interval_ms = 32'd0;
      c.resync_gap_ms    = 32'd1000;
      c.jump_threshold   = LEVEL_MAX;
      c.critical_level   = 7'd20;
      c.full_level       = LEVEL_MAX;
      run_phase(c, 60, 125, 1'b0);

      // small threshold, stepping on a timer, resync only on a gap of all ones
      c.stable_window_ms = 32'd0;
      c.step_interval_ms = 32'd100;
      c.resync_gap_ms    = 32'hFFFF_FFFF;
      c.jump_threshold   = 7'd3;
      c.critical_level   = 7'd10;
      c.full_level       = 7'd90;
      run_phase(c, 80, 125, 1'b0);

      drain_displays();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** battery_level_display_smoother_top: PASSED **");
      end else begin
         $display("** battery_level_display_smoother_top: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("** battery_level_display_smoother_top: FAILED **");
      $finish;
   end

endmodule
